// File: rtl/core/mesh_parent_join_selector_macros.svh
// Assertion macros for the mesh parent join selector.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MESH_PARENT_JOIN_SELECTOR_MACROS_SVH
`define MESH_PARENT_JOIN_SELECTOR_MACROS_SVH

`ifndef ASSERT_OFF
`define MPJS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define MPJS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define MPJS_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define MPJS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/mpjs_pkg.sv
// Shared types and constants for the mesh parent join selector.
// No dependencies; used by mpjs_rank, mesh_parent_join_selector and the testbench.
package mpjs_pkg;

    localparam int MAX_CAND = 5;
    localparam int CNT_W    = $clog2(MAX_CAND + 1);
    localparam int IDX_W    = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
    localparam int MAC_W    = 48;
    localparam int RSSI_W   = 8;
    localparam int TS_W     = 32;
    localparam int REG_W    = 20;

    typedef logic [MAC_W-1:0]         mac_t;
    typedef logic signed [RSSI_W-1:0] rssi_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_FOUND = 2'd1,
        CMD_RESP  = 2'd2,
        CMD_SEND  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PROBE   = 2'd1,
        ACT_CONNECT = 2'd2,
        ACT_JOIN    = 2'd3
    } act_t;

    localparam logic [1:0] REG_PROBE   = 2'd0;
    localparam logic [1:0] REG_CONNECT = 2'd1;
    localparam logic [1:0] REG_GATHER  = 2'd2;

    // search results over the candidate table
    typedef struct packed {
        idx_t strong_idx;
        idx_t weak_idx;
        logic hit;
        idx_t hit_idx;
    } rank_t;

endpackage

// File: rtl/core/mpjs_rank.sv
// Candidate table search: strongest live entry, first weakest entry, MAC match.
// Depends on mpjs_pkg.
module mpjs_rank (
    input  mpjs_pkg::mac_t  cand_mac  [mpjs_pkg::MAX_CAND],
    input  mpjs_pkg::rssi_t cand_rssi [mpjs_pkg::MAX_CAND],
    input  mpjs_pkg::cnt_t  cnt,
    input  mpjs_pkg::mac_t  peer,
    output mpjs_pkg::rank_t rank
);

    always_comb begin
        rank = '0;
        // strongest among live entries, earliest wins ties
        for (int i = 1; i < mpjs_pkg::MAX_CAND; i++) begin
            if (mpjs_pkg::CNT_W'(i) < cnt && cand_rssi[i] > cand_rssi[rank.strong_idx]) begin
                rank.strong_idx = mpjs_pkg::IDX_W'(i);
            end
        end
        // weakest over a full table, earliest wins ties
        for (int i = 1; i < mpjs_pkg::MAX_CAND; i++) begin
            if (cand_rssi[i] < cand_rssi[rank.weak_idx]) begin
                rank.weak_idx = mpjs_pkg::IDX_W'(i);
            end
        end
        // first live entry with this MAC
        for (int i = mpjs_pkg::MAX_CAND - 1; i >= 0; i--) begin
            if (mpjs_pkg::CNT_W'(i) < cnt && cand_mac[i] == peer) begin
                rank.hit     = 1'b1;
                rank.hit_idx = mpjs_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// File: rtl/core/mesh_parent_join_selector.sv
// Mesh parent join selector: request is registered, then one combinational pass
// decides the action and updates the candidate table; result goes to an output register.
// Input register, then output register to m_tvalid. Throughput: one request per cycle
// while m_tready stays high; a stalled result holds the request in the input register.
// Reset (aresetn low, synchronous): searching set, table empty, timestamps and pending
// send cleared, registers back to 500/50/5000 ticks. Depends on mpjs_pkg and mpjs_rank.
`include "mesh_parent_join_selector_macros.svh"

module mesh_parent_join_selector (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now[31:0], peer_mac[79:32], rssi[87:80], accept[88], root_mac_in[136:89],
    // peer_is_child[137], is_connected[138], is_root[139], send_ok[140], zero[143:141]
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,   // command[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // target_mac[47:0], root_mac_out[95:48]
    output logic [95:0]  m_tdata,
    output logic [1:0]   m_tuser,   // action[1:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_data
);

    localparam int MAX = mpjs_pkg::MAX_CAND;

    logic [19:0]     probe_reg, conn_to_reg, gather_reg;
    logic            in_valid_reg;
    logic [143:0]    in_data_reg;
    logic [1:0]      in_user_reg;
    logic            out_valid_reg;
    logic [95:0]     out_data_reg;
    logic [1:0]      out_user_reg;

    logic            searching_reg, searching_next;
    mpjs_pkg::cnt_t  cnt_reg, cnt_next;
    logic [31:0]     first_reg, first_next;
    logic [31:0]     probe_t_reg, probe_t_next;
    logic [31:0]     conn_t_reg, conn_t_next;
    logic            pending_reg, pending_next;
    mpjs_pkg::mac_t  mac_reg  [MAX];
    mpjs_pkg::mac_t  mac_next [MAX];
    mpjs_pkg::rssi_t rssi_reg  [MAX];
    mpjs_pkg::rssi_t rssi_next [MAX];

    logic            fire;
    mpjs_pkg::cmd_t  cmd;
    logic [31:0]     now;
    mpjs_pkg::mac_t  peer, root_in;
    mpjs_pkg::rssi_t rssi;
    logic            accept, is_child, is_conn, is_root, send_ok;
    mpjs_pkg::rank_t rank;

    logic            gather_done, tick_restart, tick_search, probe_due, conn_due;
    mpjs_pkg::act_t  act_next;
    mpjs_pkg::mac_t  tgt_next, root_next;
    logic            wr_en, rm_en;
    mpjs_pkg::idx_t  wr_idx, rm_idx;

    function automatic logic elapsed(logic [31:0] t, logic [31:0] stamp, logic [19:0] span);
        logic [31:0] diff;
        diff = t - stamp;
        return diff >= {12'd0, span};
    endfunction

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign cfg_ready = 1'b1;

    assign cmd      = mpjs_pkg::cmd_t'(in_user_reg);
    assign now      = in_data_reg[31:0];
    assign peer     = in_data_reg[79:32];
    assign rssi     = in_data_reg[87:80];
    assign accept   = in_data_reg[88];
    assign root_in  = in_data_reg[136:89];
    assign is_child = in_data_reg[137];
    assign is_conn  = in_data_reg[138];
    assign is_root  = in_data_reg[139];
    assign send_ok  = in_data_reg[140];

    mpjs_rank u_rank (
        .cand_mac  (mac_reg),
        .cand_rssi (rssi_reg),
        .cnt       (cnt_reg),
        .peer      (peer),
        .rank      (rank)
    );

    assign gather_done  = searching_reg && (cnt_reg != '0) && elapsed(now, first_reg, gather_reg);
    assign tick_restart = !searching_reg && (cnt_reg == '0);
    assign tick_search  = (searching_reg && !gather_done) || tick_restart;
    assign probe_due    = elapsed(now, tick_restart ? 32'd0 : probe_t_reg, probe_reg);
    assign conn_due     = elapsed(now, conn_t_reg, conn_to_reg);

    always_comb begin
        searching_next = searching_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        probe_t_next   = probe_t_reg;
        conn_t_next    = conn_t_reg;
        pending_next   = pending_reg;
        act_next       = mpjs_pkg::ACT_NONE;
        tgt_next       = '0;
        root_next      = '0;
        wr_en          = 1'b0;
        wr_idx         = rank.hit_idx;
        rm_en          = 1'b0;
        rm_idx         = rank.strong_idx;
        unique case (cmd)
            mpjs_pkg::CMD_TICK: begin
                if (!is_conn && !pending_reg) begin
                    searching_next = tick_search;
                    if (tick_restart) begin
                        cnt_next     = '0;
                        first_next   = '0;
                        probe_t_next = '0;
                        conn_t_next  = '0;
                    end
                    if (tick_search) begin
                        if (probe_due) begin
                            act_next     = mpjs_pkg::ACT_PROBE;
                            tgt_next     = '1;
                            probe_t_next = now;
                        end
                    end else if (conn_due) begin
                        act_next     = mpjs_pkg::ACT_CONNECT;
                        tgt_next     = mac_reg[rank.strong_idx];
                        rm_en        = 1'b1;
                        cnt_next     = cnt_reg - mpjs_pkg::CNT_W'(1);
                        pending_next = 1'b1;
                    end
                end
            end
            mpjs_pkg::CMD_FOUND: begin
                if (!is_conn && searching_reg && !is_child) begin
                    if (cnt_reg == '0) begin
                        first_next = now;
                    end
                    wr_en = 1'b1;
                    if (rank.hit) begin
                        wr_idx = rank.hit_idx;
                    end else if (cnt_reg >= mpjs_pkg::CNT_W'(MAX)) begin
                        wr_idx = rank.weak_idx;
                    end else begin
                        wr_idx   = mpjs_pkg::IDX_W'(cnt_reg);
                        cnt_next = cnt_reg + mpjs_pkg::CNT_W'(1);
                    end
                end
            end
            mpjs_pkg::CMD_RESP: begin
                if (!is_root && !is_conn && !is_child) begin
                    if (accept) begin
                        act_next       = mpjs_pkg::ACT_JOIN;
                        tgt_next       = peer;
                        root_next      = root_in;
                        searching_next = 1'b1;
                        cnt_next       = '0;
                        first_next     = '0;
                        probe_t_next   = '0;
                        conn_t_next    = '0;
                    end else begin
                        if (rank.hit) begin
                            rm_en    = 1'b1;
                            rm_idx   = rank.hit_idx;
                            cnt_next = cnt_reg - mpjs_pkg::CNT_W'(1);
                        end
                        conn_t_next = '0;
                    end
                end
            end
            mpjs_pkg::CMD_SEND: begin
                if (pending_reg) begin
                    pending_next = 1'b0;
                    if (send_ok) begin
                        conn_t_next = now;
                    end
                end
            end
            default: ;
        endcase
    end

    // table update: shift down past a removed entry, or write one entry
    always_comb begin
        for (int i = 0; i < MAX; i++) begin
            mac_next[i]  = mac_reg[i];
            rssi_next[i] = rssi_reg[i];
        end
        for (int i = 0; i < MAX - 1; i++) begin
            if (rm_en && mpjs_pkg::IDX_W'(i) >= rm_idx) begin
                mac_next[i]  = mac_reg[i+1];
                rssi_next[i] = rssi_reg[i+1];
            end
        end
        for (int i = 0; i < MAX; i++) begin
            if (wr_en && wr_idx == mpjs_pkg::IDX_W'(i)) begin
                mac_next[i]  = peer;
                rssi_next[i] = rssi;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg     <= 20'd500;
            conn_to_reg   <= 20'd50;
            gather_reg    <= 20'd5000;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            searching_reg <= 1'b1;
            cnt_reg       <= '0;
            first_reg     <= '0;
            probe_t_reg   <= '0;
            conn_t_reg    <= '0;
            pending_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    mpjs_pkg::REG_PROBE:   probe_reg   <= cfg_data;
                    mpjs_pkg::REG_CONNECT: conn_to_reg <= cfg_data;
                    mpjs_pkg::REG_GATHER:  gather_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                searching_reg <= searching_next;
                cnt_reg       <= cnt_next;
                first_reg     <= first_next;
                probe_t_reg   <= probe_t_next;
                conn_t_reg    <= conn_t_next;
                pending_reg   <= pending_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (fire) begin
            out_data_reg <= {root_next, tgt_next};
            out_user_reg <= act_next;
            for (int i = 0; i < MAX; i++) begin
                mac_reg[i]  <= mac_next[i];
                rssi_reg[i] <= rssi_next[i];
            end
        end
    end

    `MPJS_ASSERT_IMPLY(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= mpjs_pkg::CNT_W'(MAX))
    `MPJS_ASSERT_NEXT(a_connect_pending, aclk, aresetn, fire && act_next == mpjs_pkg::ACT_CONNECT, pending_reg)
    `MPJS_ASSERT_IMPLY(a_pending_quiet, aclk, aresetn, fire && cmd == mpjs_pkg::CMD_TICK && pending_reg, act_next == mpjs_pkg::ACT_NONE)
    `MPJS_ASSERT_NEXT(a_join_restart, aclk, aresetn, fire && act_next == mpjs_pkg::ACT_JOIN, searching_reg && cnt_reg == '0)

endmodule

// File: dv/testbench.sv
// Self-checking bench for mesh_parent_join_selector: a queue-fed driver, a result monitor and
// an in-bench model of the candidate table that predicts the action for every request.
// Depends on mpjs_pkg and the mesh_parent_join_selector RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef mpjs_pkg::mac_t  mac_t;
    typedef mpjs_pkg::rssi_t rssi_t;
    typedef mpjs_pkg::cmd_t  cmd_t;
    typedef mpjs_pkg::act_t  act_t;

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_CAND = mpjs_pkg::MAX_CAND;
    localparam mac_t MAC_ZERO = '0;
    localparam mac_t MAC_ONES = '1;
    localparam mac_t MAC_A = 48'h0123_4567_89ab;
    localparam mac_t MAC_B = 48'h5a5a_0f0f_c3c3;
    localparam mac_t MAC_C = 48'ha5a5_f0f0_3c3c;
    localparam mac_t MAC_D = 48'h7e00_0000_0081;
    localparam mac_t MAC_E = 48'h0000_dead_0001;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] now;
        mac_t        peer;
        rssi_t       rssi;
        logic        accept;
        mac_t        root;
        logic        child;
        logic        conn;
        logic        is_root;
        logic        send_ok;
    } join_req_t;

    typedef struct {
        act_t action;
        mac_t target;
        mac_t root;
    } join_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [1:0]   s_tuser = mpjs_pkg::CMD_TICK;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = mpjs_pkg::REG_PROBE;
    logic [19:0]  cfg_data = '0;

    mesh_parent_join_selector dut (.*);

    always begin
        #2 aclk = ~aclk;
    end

    // model state
    logic [19:0] probe_ticks, connect_ticks, gather_ticks;
    bit          searching, send_pending;
    int          n_cand;
    mac_t        cand_mac [MAX_CAND];
    rssi_t       cand_rssi [MAX_CAND];
    logic [31:0] first_found_t, last_probe_t, last_connect_t;

    join_req_t pending_events[$];
    join_res_t due_actions[$];
    join_req_t sent_req;
    bit        s_fire, m_fire, s_calm, m_calm;
    int        s_wait, m_wait, n_err, idle_cycles, stride;
    mac_t      peer_pool [6];

    function automatic void add_event(join_req_t r);
        pending_events.insert(pending_events.size(), r);
    endfunction

    function automatic bit lapsed(logic [31:0] t, logic [31:0] stamp, logic [19:0] span);
        logic [31:0] d;
        d = t - stamp;
        return d >= {12'd0, span};
    endfunction

    function automatic void restart_search();
        searching = 1'b1;
        n_cand = 0;
        first_found_t = '0;
        last_probe_t = '0;
        last_connect_t = '0;
    endfunction

    function automatic void drop_cand(int k);
        for (int i = k; i + 1 < n_cand; i++) begin
            cand_mac[i] = cand_mac[i + 1];
            cand_rssi[i] = cand_rssi[i + 1];
        end
        if (n_cand > 0) n_cand--;
    endfunction

    function automatic join_res_t next_join_action(join_req_t r);
        join_res_t res;
        int k;
        bit hit;
        res.action = mpjs_pkg::ACT_NONE;
        res.target = '0;
        res.root = '0;
        hit = 1'b0;
        k = 0;
        case (r.cmd)
            mpjs_pkg::CMD_TICK: begin
                if (!r.conn && !send_pending) begin
                    if (searching && n_cand > 0 && lapsed(r.now, first_found_t, gather_ticks))
                        searching = 1'b0;
                    if (!searching && n_cand == 0) restart_search();
                    if (searching) begin
                        if (lapsed(r.now, last_probe_t, probe_ticks)) begin
                            res.action = mpjs_pkg::ACT_PROBE;
                            res.target = '1;
                            last_probe_t = r.now;
                        end
                    end else if (lapsed(r.now, last_connect_t, connect_ticks)) begin
                        for (int i = 1; i < n_cand; i++)
                            if (cand_rssi[i] > cand_rssi[k]) k = i;
                        res.action = mpjs_pkg::ACT_CONNECT;
                        res.target = cand_mac[k];
                        drop_cand(k);
                        send_pending = 1'b1;
                    end
                end
            end
            mpjs_pkg::CMD_FOUND: begin
                if (!r.conn && searching && !r.child) begin
                    if (n_cand == 0) first_found_t = r.now;
                    for (int i = 0; i < n_cand && !hit; i++) begin
                        if (cand_mac[i] == r.peer) begin
                            cand_rssi[i] = r.rssi;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        if (n_cand >= MAX_CAND) begin
                            for (int i = 1; i < MAX_CAND; i++)
                                if (cand_rssi[i] < cand_rssi[k]) k = i;
                            cand_mac[k] = r.peer;
                            cand_rssi[k] = r.rssi;
                        end else begin
                            cand_mac[n_cand] = r.peer;
                            cand_rssi[n_cand] = r.rssi;
                            n_cand++;
                        end
                    end
                end
            end
            mpjs_pkg::CMD_RESP: begin
                if (!r.is_root && !r.conn && !r.child) begin
                    if (r.accept) begin
                        res.action = mpjs_pkg::ACT_JOIN;
                        res.target = r.peer;
                        res.root = r.root;
                        restart_search();
                    end else begin
                        for (int i = 0; i < n_cand && !hit; i++) begin
                            if (cand_mac[i] == r.peer) begin
                                drop_cand(i);
                                hit = 1'b1;
                            end
                        end
                        last_connect_t = '0;
                    end
                end
            end
            default: begin
                if (send_pending) begin
                    send_pending = 1'b0;
                    if (r.send_ok) last_connect_t = r.now;
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [143:0] pack_event(join_req_t r);
        return {3'b000, r.send_ok, r.is_root, r.conn, r.child, r.root, r.accept, r.rssi,
                r.peer, r.now};
    endfunction

    function automatic mac_t rand_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    function automatic join_req_t make_req(cmd_t c, logic [31:0] t, mac_t peer, int rs,
                                           bit acc, mac_t root, bit child, bit conn,
                                           bit is_root, bit ok);
        join_req_t r;
        r.cmd = c;
        r.now = t;
        r.peer = peer;
        r.rssi = rssi_t'(rs);
        r.accept = acc;
        r.root = root;
        r.child = child;
        r.conn = conn;
        r.is_root = is_root;
        r.send_ok = ok;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (n_err < 40) $display("tb: mismatch at %0t: %s", $realtime, what);
        n_err++;
    endtask

    // driver
    always @(posedge aclk) begin
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) due_actions.insert(due_actions.size(), next_join_action(sent_req));
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) begin
                if ($urandom_range(0, 63) == 0) s_calm = !s_calm;
                s_wait = s_calm ? 0 : $urandom_range(0, 4);
            end
            if (s_fire || !s_tvalid) begin
                if (s_wait > 0) begin
                    s_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    sent_req = pending_events.pop_front();
                    s_tdata <= pack_event(sent_req);
                    s_tuser <= sent_req.cmd;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        join_res_t e;
        m_fire = aresetn && m_tvalid && m_tready;
        if (m_fire) begin
            if (due_actions.size() == 0) begin
                report_mismatch($sformatf("unexpected result action %0d", m_tuser));
            end else begin
                e = due_actions.pop_front();
                if (m_tuser !== e.action)
                    report_mismatch($sformatf("action %0d, want %0d", m_tuser, e.action));
                if (m_tdata[47:0] !== e.target)
                    report_mismatch($sformatf("target_mac %h, want %h", m_tdata[47:0],
                                              e.target));
                if (m_tdata[95:48] !== e.root)
                    report_mismatch($sformatf("root_mac_out %h, want %h", m_tdata[95:48],
                                              e.root));
            end
        end
    end

    always @(negedge aclk) begin
        if (m_fire) begin
            if ($urandom_range(0, 49) == 0) m_calm = !m_calm;
            m_wait = m_calm ? 0 : $urandom_range(0, 4);
        end
        if (m_wait > 0) begin
            m_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            mpjs_pkg::REG_PROBE:   probe_ticks = val;
            mpjs_pkg::REG_CONNECT: connect_ticks = val;
            mpjs_pkg::REG_GATHER:  gather_ticks = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [19:0] p, logic [19:0] c, logic [19:0] g);
        int hi;
        write_reg(mpjs_pkg::REG_PROBE, p);
        write_reg(mpjs_pkg::REG_CONNECT, c);
        write_reg(mpjs_pkg::REG_GATHER, g);
        hi = int'(p);
        if (int'(c) > hi) hi = int'(c);
        if (int'(g) > hi) hi = int'(g);
        stride = hi / 4 + 4;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_events.size() > 0 || s_tvalid || due_actions.size() > 0);
    endtask

    task automatic queue_random(int n, logic [31:0] t0);
        logic [31:0] t;
        int c;
        cmd_t cmd;
        t = t0;
        foreach (peer_pool[i]) peer_pool[i] = rand_mac();
        for (int j = 0; j < n; j++) begin
            c = $urandom_range(0, 99);
            cmd = (c < 40) ? mpjs_pkg::CMD_TICK : (c < 70) ? mpjs_pkg::CMD_FOUND :
                  (c < 82) ? mpjs_pkg::CMD_RESP : mpjs_pkg::CMD_SEND;
            if ($urandom_range(0, 3) != 0) t = t + $urandom_range(1, stride);
            add_event(make_req(
                cmd,
                ($urandom_range(0, 19) == 0) ? $urandom() : t,
                ($urandom_range(0, 3) == 0) ? rand_mac() : peer_pool[$urandom_range(0, 5)],
                $urandom_range(0, 255) - 128,
                $urandom_range(0, 9) < 3,
                rand_mac(),
                $urandom_range(0, 9) == 0,
                $urandom_range(0, 11) == 0,
                $urandom_range(0, 9) == 0,
                $urandom_range(0, 3) != 0));
        end
    endtask

    initial begin
        probe_ticks = 20'd500;
        connect_ticks = 20'd50;
        gather_ticks = 20'd5000;
        send_pending = 1'b0;
        restart_search();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed pass at reset register values
        add_event(make_req(mpjs_pkg::CMD_TICK, 0, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_TICK, 500, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_FOUND, 550, MAC_A, 1, 0, MAC_ZERO, 0, 1, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_FOUND, 560, MAC_A, 1, 0, MAC_ZERO, 1, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_FOUND, 600, MAC_ZERO, -128, 0, MAC_ZERO,
                           0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_FOUND, 601, MAC_ONES, 127, 1, MAC_ONES,
                           0, 0, 0, 1));
        add_event(make_req(mpjs_pkg::CMD_FOUND, 602, MAC_A, 127, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_FOUND, 603, MAC_ZERO, 5, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_FOUND, 604, MAC_B, -128, 0, MAC_ZERO,
                           0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_FOUND, 605, MAC_C, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        // table full: replaces the first weakest entry
        add_event(make_req(mpjs_pkg::CMD_FOUND, 606, MAC_D, -100, 0, MAC_ZERO,
                           0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_RESP, 607, MAC_A, 0, 1, MAC_ONES, 1, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_RESP, 608, MAC_A, 0, 1, MAC_ONES, 0, 0, 1, 0));
        add_event(make_req(mpjs_pkg::CMD_RESP, 609, MAC_A, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_TICK, 1000, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_TICK, 5600, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_TICK, 5700, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_SEND, 5601, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 1));
        add_event(make_req(mpjs_pkg::CMD_SEND, 5602, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 1));
        add_event(make_req(mpjs_pkg::CMD_TICK, 5610, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_TICK, 5651, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_SEND, 5660, MAC_ZERO, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_RESP, 5670, MAC_ONES, 0, 1, MAC_ONES, 0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_TICK, 32'hffff_ffff, MAC_ZERO, 0, 0, MAC_ZERO,
                           0, 1, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_TICK, 32'hffff_ffff, MAC_ZERO, 0, 0, MAC_ZERO,
                           0, 0, 0, 0));
        add_event(make_req(mpjs_pkg::CMD_RESP, 3, MAC_E, 0, 0, MAC_ZERO, 0, 0, 0, 0));
        wait_drained();

        set_regs(20'd1, 20'd1, 20'd1);
        queue_random(130, $urandom());
        wait_drained();
        set_regs(20'd20, 20'd5, 20'd60);
        queue_random(130, $urandom());
        wait_drained();
        set_regs(20'd1000000, 20'd1000000, 20'd1000000);
        queue_random(130, 32'hffff_fff0);
        wait_drained();
        set_regs(20'd0, 20'd0, 20'd0);
        queue_random(130, $urandom());
        wait_drained();
        set_regs(20'hfffff, 20'd3, 20'hfffff);
        write_reg(REG_NONE, 20'($urandom()));
        queue_random(130, $urandom());
        wait_drained();
        set_regs(20'd500, 20'd50, 20'd5000);
        queue_random(130, $urandom());
        wait_drained();
        repeat (2) begin
            set_regs(20'($urandom_range(1, 40)), 20'($urandom_range(1, 40)),
                     20'($urandom_range(1, 200)));
            queue_random(130, $urandom());
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
